/* rtl/digit_rounding_quantizer_unit_macros.svh */
// assertion macros for the digit rounding quantizer
// used by the top level only, expects clk and arst_n in scope
`ifndef DIGIT_ROUNDING_QUANTIZER_UNIT_MACROS_SVH
`define DIGIT_ROUNDING_QUANTIZER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define DRQU_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("drqu check failed");
`define DRQU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("drqu check failed");
`else
`define DRQU_ASSERT_SAME(lbl, ante, cons)
`define DRQU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/drqu_pkg.sv */
// shared types, register codes and fixed-point constants of the quantizer
// no dependencies
package drqu_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW = 2;

	localparam logic [3:0] CFG_SIG_DIGITS  = 4'd0;
	localparam logic [3:0] CFG_ELEM_FORMAT = 4'd1;

	localparam int FXB = 48;
	localparam logic [34:0] DEC_DEN = 35'd1000000000;

	// nearest 48-bit fraction of num / 1e9, evaluated at elaboration
	function automatic logic [50:0] fx_const(input logic [33:0] num);
		logic [81:0] n;
		logic [81:0] q;
		logic [34:0] rem;
		int b;
		n = 82'(num) << FXB;
		q = '0;
		rem = '0;
		for (b = 81; b >= 0; b--) begin
			rem = {rem[33:0], n[b]};
			if (rem >= DEC_DEN) begin
				rem = rem - DEC_DEN;
				q[b] = 1'b1;
			end
		end
		if ({rem, 1'b0} >= 36'(DEC_DEN))
			q = q + 82'd1;
		return q[50:0];
	endfunction

	localparam logic [50:0] FX_L2  = fx_const(34'd301029996);
	localparam logic [50:0] FX_L10 = fx_const(34'd3321928095);
	localparam logic [50:0] FX_LOG [5] = '{
		fx_const(34'd301029996), fx_const(34'd221848749), fx_const(34'd154901959),
		fx_const(34'd96910013), fx_const(34'd45757490)};

	// thresholds 0.6 .. 0.9 against ten times a significand normalized to bit 52
	localparam logic [56:0] THR [4] = '{
		57'(6) << 53, 57'(7) << 53, 57'(8) << 53, 57'(9) << 53};

	typedef enum logic [1:0] {SEL_KEEP, SEL_INC, SEL_MASK, SEL_POW} sel_t;

	typedef struct packed {
		logic [63:0]        raw;
		logic               last;
		logic               fmt;
		logic               pass;
		logic [52:0]        m;
		logic signed [12:0] e0;
	} item_t;

	typedef struct packed {
		logic [2:0] count;
		logic       full;
		logic       empty;
	} qstat_t;

endpackage

/* rtl/drqu_front.sv */
// front end: takes stream items, unpacks and classifies them into one register
// depends on drqu_pkg
module drqu_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [63:0]         s_tdata,   // value_bits
	input  logic                s_tlast,
	input  logic                fmt,
	input  drqu_pkg::qstat_t    qstat,
	output logic                push,
	output drqu_pkg::item_t     push_item
);
	import drqu_pkg::*;

	logic     v_s1;
	item_t    item_s1;
	item_t    item_c;
	logic [10:0] ex;
	logic [51:0] fr;
	logic     ex_max;

	assign push = v_s1 && !qstat.full;
	assign s_tready = !v_s1 || !qstat.full;
	assign push_item = item_s1;

	always_comb begin
		item_c.last = s_tlast;
		item_c.fmt = fmt;
		if (fmt) begin
			item_c.raw = {32'd0, s_tdata[31:0]};
			ex = {3'd0, s_tdata[30:23]};
			fr = {29'd0, s_tdata[22:0]};
			ex_max = (s_tdata[30:23] == 8'hFF);
			item_c.m = {29'd0, (ex != 11'd0), fr[22:0]};
			item_c.e0 = ((ex != 11'd0) ? 13'(ex) : 13'd1) - 13'd150;
		end else begin
			item_c.raw = s_tdata;
			ex = s_tdata[62:52];
			fr = s_tdata[51:0];
			ex_max = (s_tdata[62:52] == 11'h7FF);
			item_c.m = {(ex != 11'd0), fr};
			item_c.e0 = ((ex != 11'd0) ? 13'(ex) : 13'd1) - 13'd1075;
		end
		item_c.pass = ex_max || (ex == 11'd0 && fr == 52'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_c;
		end
	end

endmodule

/* rtl/drqu_queue.sv */
// short queue between front and back ends
// depends on drqu_pkg
module drqu_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  drqu_pkg::item_t     push_item,
	input  logic                pop,
	output drqu_pkg::item_t     pop_item,
	output drqu_pkg::qstat_t    qstat
);
	import drqu_pkg::*;

	item_t           mem [QDEPTH];
	logic [QAW-1:0]  wr_q;
	logic [QAW-1:0]  rd_q;
	logic [QAW:0]    count_q;
	logic            do_push;
	logic            do_pop;

	assign qstat.count = count_q;
	assign qstat.full = (count_q == (QAW+1)'(QDEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_push = push && !qstat.full;
	assign do_pop = pop && !qstat.empty;
	assign pop_item = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_q] <= push_item;
	end

endmodule

/* rtl/drqu_back.sv */
// back end: log10 estimate, step exponent and bit clearing or power-of-two fallback, then output register
// depends on drqu_pkg
module drqu_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop,
	input  drqu_pkg::item_t     pop_item,
	input  logic [4:0]          nsd,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [63:0]         m_tdata,   // rounded_bits
	output logic                m_tlast
);
	import drqu_pkg::*;

	logic en;
	logic v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	item_t item_s2, item_s3, item_s4, item_s5, item_s6;
	logic [5:0] k_s2, k_s3, k_s4, k_s5;
	logic signed [12:0] e_s2, e_s3;
	logic [2:0] idx_s3;
	logic signed [10:0] d_s4;
	logic signed [12:0] p_s5;
	sel_t sel_s6;
	logic [5:0] j_s6;
	logic [63:0] pow_s6;
	logic [63:0] data_s7;
	logic last_s7;

	logic [5:0] k_c;
	logic [52:0] mn;
	logic [56:0] ten;
	logic [2:0] idx_c;
	logic signed [63:0] x_c;
	logic signed [11:0] dm;
	logic signed [63:0] y_c;
	logic signed [13:0] j_c;
	logic signed [13:0] tb;
	logic signed [13:0] sh;
	logic [5:0] fb;
	logic [10:0] emax;
	logic [63:0] pow_c;
	sel_t sel_c;
	logic [63:0] low_mask;
	logic [63:0] res_c;

	assign en = !v_s7 || m_tready;
	assign pop = en;
	assign m_tvalid = v_s7;
	assign m_tdata = data_s7;
	assign m_tlast = last_s7;

	// leading one of the significand
	always_comb begin
		k_c = '0;
		for (int b = 0; b < 53; b++) begin
			if (pop_item.m[b])
				k_c = 6'(b);
		end
	end

	// table index: thresholds strictly below the significand
	always_comb begin
		mn = item_s2.m << (6'd52 - k_s2);
		ten = (57'(mn) << 3) + (57'(mn) << 1);
		idx_c = 3'(ten > THR[0]) + 3'(ten > THR[1]) + 3'(ten > THR[2]) + 3'(ten > THR[3]);
	end

	assign x_c = $signed(e_s3) * $signed({1'b0, FX_L2}) - $signed({13'd0, FX_LOG[idx_s3]});
	assign dm = $signed({d_s4[10], d_s4}) - $signed({7'd0, nsd});
	assign y_c = dm * $signed({1'b0, FX_L10});

	// step position relative to the significand, and the power-of-two fallback
	always_comb begin
		j_c = $signed({p_s5[12], p_s5}) - $signed({item_s5.e0[12], item_s5.e0});
		fb = item_s5.fmt ? 6'd23 : 6'd52;
		emax = item_s5.fmt ? 11'd255 : 11'd2047;
		tb = $signed({p_s5[12], p_s5}) - 14'sd1 + (item_s5.fmt ? 14'sd127 : 14'sd1023);
		sh = tb - 14'sd1 + $signed({8'd0, fb});
		if (tb >= $signed({3'd0, emax}))
			pow_c = 64'(emax) << fb;
		else if (tb >= 14'sd1)
			pow_c = 64'(tb[10:0]) << fb;
		else if (sh >= 14'sd0 && sh < $signed({8'd0, fb}))
			pow_c = 64'd1 << sh[5:0];
		else
			pow_c = '0;
		if (item_s5.fmt)
			pow_c[31] = item_s5.raw[31];
		else
			pow_c[63] = item_s5.raw[63];
		if (item_s5.pass || j_c < 14'sd0)
			sel_c = SEL_KEEP;
		else if (j_c == 14'sd0)
			sel_c = item_s5.m[0] ? SEL_INC : SEL_KEEP;
		else if (j_c <= $signed({8'd0, k_s5}))
			sel_c = SEL_MASK;
		else
			sel_c = SEL_POW;
	end

	always_comb begin
		low_mask = ~(64'hFFFF_FFFF_FFFF_FFFF << j_s6);
		unique case (sel_s6)
			SEL_KEEP: res_c = item_s6.raw;
			SEL_INC:  res_c = item_s6.raw + 64'd1;
			SEL_MASK: res_c = (item_s6.raw & ~low_mask) | (64'd1 << (j_s6 - 6'd1));
			SEL_POW:  res_c = pow_s6;
			default:  res_c = item_s6.raw;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s2 <= pop_valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s2 <= pop_item;
			k_s2 <= k_c;
			e_s2 <= pop_item.e0 + 13'(k_c) + 13'sd1;
			item_s3 <= item_s2;
			k_s3 <= k_s2;
			e_s3 <= e_s2;
			idx_s3 <= idx_c;
			item_s4 <= item_s3;
			k_s4 <= k_s3;
			d_s4 <= x_c[58:48] + 11'sd1;
			item_s5 <= item_s4;
			k_s5 <= k_s4;
			p_s5 <= y_c[60:48];
			item_s6 <= item_s5;
			sel_s6 <= sel_c;
			j_s6 <= j_c[5:0];
			pow_s6 <= pow_c;
			data_s7 <= res_c;
			last_s7 <= item_s6.last;
		end
	end

endmodule

/* rtl/digit_rounding_quantizer_unit.sv */
// digit rounding quantizer: one item per cycle sustained while m_tready is high, set by the back-end pipeline
// path from input transfer to output valid:
// (1 front register, queue of 4 entries, 6 back stages ending in the output register)
// async active-low reset empties all stages and the queue, digits go to 3, format to binary64
// configuration writes are taken every cycle
`include "digit_rounding_quantizer_unit_macros.svh"
module digit_rounding_quantizer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // value_bits
	input  logic        s_tlast,   // last_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // rounded_bits
	output logic        m_tlast,   // last_out
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [4:0]  cfg_data
);
	import drqu_pkg::*;

	logic [4:0] nsd_q;
	logic       fmt_q;
	qstat_t     qstat;
	logic       push;
	item_t      push_item;
	logic       pop;
	item_t      pop_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nsd_q <= 5'd3;
			fmt_q <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_SIG_DIGITS)
				nsd_q <= cfg_data;
			else if (cfg_index == CFG_ELEM_FORMAT)
				fmt_q <= cfg_data[0];
		end
	end

	drqu_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.fmt(fmt_q), .qstat(qstat), .push(push), .push_item(push_item)
	);

	drqu_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_item(push_item), .pop(pop), .pop_item(pop_item), .qstat(qstat)
	);

	drqu_back u_back (
		.clk(clk), .arst_n(arst_n),
		.pop_valid(!qstat.empty), .pop(pop), .pop_item(pop_item), .nsd(nsd_q),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	`DRQU_ASSERT_SAME(a_count_bound, 1'b1, qstat.count <= 3'(QDEPTH))
	`DRQU_ASSERT_NEXT(a_empty_stays, qstat.empty && !push, qstat.empty)
	`DRQU_ASSERT_SAME(a_full_no_ready, !s_tready, qstat.full)
	`DRQU_ASSERT_NEXT(a_full_drains, qstat.full && pop, !qstat.full || push)

endmodule
